/* design/rhc_pkg.sv */
// Shared constants and types for the RGB to HSV converter.
// No dependencies; every other design file imports this package.
package rhc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int IN_BITS          = 8;
  localparam int HUE_BITS         = 15;
  localparam int SAT_BITS         = 8;
  localparam int QUOT_BITS        = 12;
  localparam int SPAN_SHIFT_HI    = 12;
  localparam int SPAN_SHIFT_LO    = 8;
  localparam int SAT_SHIFT        = 8;

  localparam logic [HUE_BITS-1:0] BASE_RED   = 15'd0;
  localparam logic [HUE_BITS-1:0] BASE_GREEN = 15'd7680;
  localparam logic [HUE_BITS-1:0] BASE_BLUE  = 15'd15360;
  localparam logic [HUE_BITS-1:0] FULL_TURN  = 15'd23040;

  localparam logic [1:0] SECTOR_RED   = 2'd0;
  localparam logic [1:0] SECTOR_GREEN = 2'd1;
  localparam logic [1:0] SECTOR_BLUE  = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       gray;
    logic       neg;
    logic [1:0] sector;
  } ctl_t;

endpackage

/* design/rgb_to_hsv_converter_core.sv */
// Top level of the RGB to HSV converter: front stage, division cells, output stage.
// Depends on rhc_pkg, rhc_front, rhc_cell and rhc_back.
//
// Usage: the input channel carries one pixel word (red, green, blue) under
// in_valid/in_ready; the output channel carries hue, saturation, brightness
// and achromatic under out_valid/out_ready. Hue is in 1/64 degree.
// The pipeline holds one front stage, one cell per quotient bit, and the output
// register. Throughput is one word per cycle while the receiver takes results;
// the division runs as a row of cells, each settling one bit of both quotients
// and passing its work on.
// When the receiver stalls, the whole row holds and in_ready drops, but a
// word is still taken while the output register is empty.
// Reset clears every valid flag; the block is ready right after reset.
module rgb_to_hsv_converter_core import rhc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_BITS-1:0]  red,
  input  logic [IN_BITS-1:0]  green,
  input  logic [IN_BITS-1:0]  blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HUE_BITS-1:0] hue,
  output logic [SAT_BITS-1:0] saturation,
  output logic [IN_BITS-1:0]  brightness,
  output logic                achromatic
);

  localparam int W  = CHANNEL_BITS;
  localparam int NW = CHANNEL_BITS + QUOT_BITS;

  logic advance;

  ctl_t                 ctl_s     [QUOT_BITS+1];
  logic [W-1:0]         hi_s      [QUOT_BITS+1];
  logic [W-1:0]         span_s    [QUOT_BITS+1];
  logic [NW-1:0]        hue_rem_s [QUOT_BITS+1];
  logic [NW-1:0]        sat_rem_s [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] hue_q_s   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] sat_q_s   [QUOT_BITS+1];

  assign advance    = !out_valid || out_ready;
  assign in_ready   = advance;
  assign hue_q_s[0] = '0;
  assign sat_q_s[0] = '0;

  rhc_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_take (in_valid),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .ctl     (ctl_s[0]),
    .hi      (hi_s[0]),
    .span    (span_s[0]),
    .hue_rem (hue_rem_s[0]),
    .sat_rem (sat_rem_s[0])
  );

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
    rhc_cell #(.CHANNEL_BITS(CHANNEL_BITS), .SHIFT(QUOT_BITS-1-k)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .ctl_in      (ctl_s[k]),
      .hi_in       (hi_s[k]),
      .span_in     (span_s[k]),
      .hue_rem_in  (hue_rem_s[k]),
      .sat_rem_in  (sat_rem_s[k]),
      .hue_q_in    (hue_q_s[k]),
      .sat_q_in    (sat_q_s[k]),
      .ctl_out     (ctl_s[k+1]),
      .hi_out      (hi_s[k+1]),
      .span_out    (span_s[k+1]),
      .hue_rem_out (hue_rem_s[k+1]),
      .sat_rem_out (sat_rem_s[k+1]),
      .hue_q_out   (hue_q_s[k+1]),
      .sat_q_out   (sat_q_s[k+1])
    );
  end

  rhc_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .ctl_in     (ctl_s[QUOT_BITS]),
    .hi_in      (hi_s[QUOT_BITS]),
    .hue_q_in   (hue_q_s[QUOT_BITS]),
    .sat_q_in   (sat_q_s[QUOT_BITS]),
    .out_valid  (out_valid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .achromatic (achromatic)
  );

endmodule

/* design/rhc_front.sv */
// Front stage: picks max and min, the hue sector and the scaled dividends.
// Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             in_take,
  input  logic [IN_BITS-1:0]               red,
  input  logic [IN_BITS-1:0]               green,
  input  logic [IN_BITS-1:0]               blue,
  output ctl_t                             ctl,
  output logic [CHANNEL_BITS-1:0]          hi,
  output logic [CHANNEL_BITS-1:0]          span,
  output logic [CHANNEL_BITS+QUOT_BITS-1:0] hue_rem,
  output logic [CHANNEL_BITS+QUOT_BITS-1:0] sat_rem
);

  localparam int W  = CHANNEL_BITS;
  localparam int NW = CHANNEL_BITS + QUOT_BITS;

  logic [W-1:0]  r, g, b, hi_c, lo_c, da, db, mag, span_c;
  logic [1:0]    sector_c;
  logic          neg_c;
  logic [NW-1:0] mag_w, span_w;
  ctl_t          ctl_next;

  always_comb begin
    r = W'(red);
    g = W'(green);
    b = W'(blue);
    if (r >= g && r >= b) begin
      sector_c = SECTOR_RED;
      hi_c     = r;
      da       = g;
      db       = b;
    end else if (g >= b) begin
      sector_c = SECTOR_GREEN;
      hi_c     = g;
      da       = b;
      db       = r;
    end else begin
      sector_c = SECTOR_BLUE;
      hi_c     = b;
      da       = r;
      db       = g;
    end
    lo_c   = (r <= g && r <= b) ? r : ((g <= b) ? g : b);
    span_c = hi_c - lo_c;
    neg_c  = da < db;
    mag    = neg_c ? (db - da) : (da - db);
    mag_w  = NW'(mag);
    span_w = NW'(span_c);
    ctl_next.valid  = in_take;
    ctl_next.gray   = span_c == '0;
    ctl_next.neg    = neg_c;
    ctl_next.sector = sector_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (advance) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hi      <= hi_c;
      span    <= span_c;
      hue_rem <= (mag_w << SPAN_SHIFT_HI) - (mag_w << SPAN_SHIFT_LO);
      sat_rem <= (span_w << SAT_SHIFT) - span_w;
    end
  end

endmodule

/* design/rhc_cell.sv */
// One division cell: settles one quotient bit of both hue and saturation.
// Depends on rhc_pkg.
module rhc_cell import rhc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int SHIFT        = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  ctl_t                              ctl_in,
  input  logic [CHANNEL_BITS-1:0]           hi_in,
  input  logic [CHANNEL_BITS-1:0]           span_in,
  input  logic [CHANNEL_BITS+QUOT_BITS-1:0] hue_rem_in,
  input  logic [CHANNEL_BITS+QUOT_BITS-1:0] sat_rem_in,
  input  logic [QUOT_BITS-1:0]              hue_q_in,
  input  logic [QUOT_BITS-1:0]              sat_q_in,
  output ctl_t                              ctl_out,
  output logic [CHANNEL_BITS-1:0]           hi_out,
  output logic [CHANNEL_BITS-1:0]           span_out,
  output logic [CHANNEL_BITS+QUOT_BITS-1:0] hue_rem_out,
  output logic [CHANNEL_BITS+QUOT_BITS-1:0] sat_rem_out,
  output logic [QUOT_BITS-1:0]              hue_q_out,
  output logic [QUOT_BITS-1:0]              sat_q_out
);

  localparam int NW = CHANNEL_BITS + QUOT_BITS;

  logic [NW-1:0]        hue_d, sat_d;
  logic                 hue_ge, sat_ge;
  logic [QUOT_BITS-1:0] hue_q_next, sat_q_next;

  always_comb begin
    hue_d      = NW'(span_in) << SHIFT;
    sat_d      = NW'(hi_in) << SHIFT;
    hue_ge     = hue_rem_in >= hue_d;
    sat_ge     = sat_rem_in >= sat_d;
    hue_q_next = hue_q_in;
    sat_q_next = sat_q_in;
    hue_q_next[SHIFT] = hue_ge;
    sat_q_next[SHIFT] = sat_ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (advance) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hi_out      <= hi_in;
      span_out    <= span_in;
      hue_rem_out <= hue_ge ? hue_rem_in - hue_d : hue_rem_in;
      sat_rem_out <= sat_ge ? sat_rem_in - sat_d : sat_rem_in;
      hue_q_out   <= hue_q_next;
      sat_q_out   <= sat_q_next;
    end
  end

endmodule

/* design/rhc_back.sv */
// Output stage: adds the sector base, wraps negative hue, holds the result word.
// Depends on rhc_pkg.
module rhc_back import rhc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  ctl_t                    ctl_in,
  input  logic [CHANNEL_BITS-1:0] hi_in,
  input  logic [QUOT_BITS-1:0]    hue_q_in,
  input  logic [QUOT_BITS-1:0]    sat_q_in,
  output logic                    out_valid,
  output logic [HUE_BITS-1:0]     hue,
  output logic [SAT_BITS-1:0]     saturation,
  output logic [IN_BITS-1:0]      brightness,
  output logic                    achromatic
);

  logic [HUE_BITS-1:0] base, q, hue_c;

  always_comb begin
    unique case (ctl_in.sector)
      SECTOR_RED:   base = BASE_RED;
      SECTOR_GREEN: base = BASE_GREEN;
      default:      base = BASE_BLUE;
    endcase
    q = HUE_BITS'(hue_q_in);
    if (ctl_in.gray) begin
      hue_c = '0;
    end else if (!ctl_in.neg) begin
      hue_c = base + q;
    end else if (q > base) begin
      hue_c = base + FULL_TURN - q;
    end else begin
      hue_c = base - q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hue        <= hue_c;
      saturation <= ctl_in.gray ? '0 : sat_q_in[SAT_BITS-1:0];
      brightness <= IN_BITS'(hi_in);
      achromatic <= ctl_in.gray;
    end
  end

endmodule

/* design/rhc_checker.sv */
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter_core.
module rhc_checker import rhc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [HUE_BITS-1:0] hue,
  input logic [SAT_BITS-1:0] saturation,
  input logic                achromatic
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation))
    else $error("Stalled result word changed.");

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && achromatic |-> hue == '0 && saturation == '0)
    else $error("Gray pixel with nonzero hue or saturation.");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue < FULL_TURN)
    else $error("Hue out of range.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("Block not empty after reset.");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (.*);
